// ===== design/lsfit_pkg.sv =====
// Shared widths, codes, command structs and constants for the line-fit block.
`default_nettype none

package lsfit_pkg;

    // Configuration of the fit
    localparam int MAX_POINTS = 4;
    localparam int FRAC_BITS  = 24;

    // Item field widths
    localparam int F_W   = 16;
    localparam int P_W   = 8;
    localparam int FX_W  = 48;
    localparam int EST_W = 16;

    // Accumulator widths
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SF_W  = F_W + CNT_W - 1;
    localparam int SFF_W = 2 * F_W + CNT_W;
    localparam int SFP_W = F_W + P_W + CNT_W - 1;
    localparam int SP_W  = P_W + CNT_W - 1;

    // Serial multiply-accumulate unit
    localparam int A_W   = FX_W;
    localparam int B_W   = SF_W;
    localparam int ACC_W = A_W + B_W;

    // Serial divider
    localparam int DEN_W     = SFF_W + CNT_W;
    localparam int NUM_W     = SFF_W + SP_W + 1;
    localparam int DIVD_W    = NUM_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIVD_W);
    localparam int Q_W       = FX_W + 1;
    localparam int QR_W      = Q_W + 1;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVD_W - 1);
    localparam logic [QR_W-1:0]      NEG_LIM  = QR_W'(1) << (FX_W - 1);
    localparam logic [QR_W-1:0]      POS_LIM  = (QR_W'(1) << (FX_W - 1)) - QR_W'(1);
    localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

    localparam logic [CNT_W-1:0] PT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] MAX_PT = CNT_W'(MAX_POINTS);

    localparam logic [ACC_W-1:0] EST_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [EST_W-1:0] EST_MAX  = {EST_W{1'b1}};

    // Request and result codes
    localparam logic REQ_CAL = 1'b0;
    localparam logic REQ_EST = 1'b1;
    localparam logic RK_FIT  = 1'b0;
    localparam logic RK_EST  = 1'b1;

    typedef struct packed {
        logic                    load;
        logic                    sub;
        logic signed [ACC_W-1:0] init;
        logic signed [A_W-1:0]   a;
        logic [B_W-1:0]          b;
    } mac_cmd_t;

    typedef struct packed {
        logic                    load;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } div_cmd_t;

endpackage

`default_nettype wire

// ===== design/lsfit_mac.sv =====
// Bit-serial shift-and-add multiply-accumulate unit: acc +/- a*b, one bit of b a cycle.
`default_nettype none

module lsfit_mac (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire lsfit_pkg::mac_cmd_t              cmd,
    output logic                                  run,
    output logic signed [lsfit_pkg::ACC_W-1:0]    acc
);

    logic                              run_reg, run_next;
    logic                              sub_reg, sub_next;
    logic signed [lsfit_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic signed [lsfit_pkg::ACC_W-1:0] a_reg, a_next;
    logic [lsfit_pkg::B_W-1:0]          b_reg, b_next;

    always_comb
    begin
        run_next = run_reg;
        sub_next = sub_reg;
        acc_next = acc_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        if (cmd.load)
        begin
            run_next = 1'b1;
            sub_next = cmd.sub;
            acc_next = cmd.init;
            a_next   = {{(lsfit_pkg::ACC_W-lsfit_pkg::A_W){cmd.a[lsfit_pkg::A_W-1]}}, cmd.a};
            b_next   = cmd.b;
        end
        else if (run_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = sub_reg ? (acc_reg - a_reg) : (acc_reg + a_reg);
            end
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            run_next = (b_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_reg <= sub_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign run = run_reg;
    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== design/lsfit_div.sv =====
// Restoring radix-2 divider: (num << FRAC_BITS) / den, rounded half away from zero, saturated.
`default_nettype none

module lsfit_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lsfit_pkg::div_cmd_t             cmd,
    output logic                                 run,
    output logic signed [lsfit_pkg::FX_W-1:0]    quot
);

    logic                                run_reg, run_next;
    logic [lsfit_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [lsfit_pkg::DIVD_W-1:0]        dvd_reg, dvd_next;
    logic [lsfit_pkg::DEN_W-1:0]         rem_reg, rem_next;
    logic [lsfit_pkg::DEN_W-1:0]         den_reg, den_next;
    logic [lsfit_pkg::Q_W-1:0]           q_reg, q_next;
    logic                                ovf_reg, ovf_next;
    logic                                neg_reg, neg_next;

    logic [lsfit_pkg::NUM_W-1:0]         mag;
    logic [lsfit_pkg::DEN_W:0]           rem_sh;
    logic [lsfit_pkg::DEN_W:0]           rem_sub;
    logic                                ge;
    logic                                rnd;
    logic [lsfit_pkg::QR_W-1:0]          q_rnd;
    logic                                sat;

    assign mag = cmd.num[lsfit_pkg::NUM_W-1] ? (~$unsigned(cmd.num) + 1'b1)
                                             : $unsigned(cmd.num);

    // one quotient bit per cycle
    assign rem_sh  = {rem_reg, dvd_reg[lsfit_pkg::DIVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        q_next   = q_reg;
        ovf_next = ovf_reg;
        neg_next = neg_reg;
        if (cmd.load)
        begin
            run_next = 1'b1;
            cnt_next = lsfit_pkg::DIV_LAST;
            dvd_next = {mag, {lsfit_pkg::FRAC_BITS{1'b0}}};
            rem_next = '0;
            den_next = cmd.den;
            q_next   = '0;
            ovf_next = 1'b0;
            neg_next = cmd.num[lsfit_pkg::NUM_W-1];
        end
        else if (run_reg)
        begin
            rem_next = ge ? rem_sub[lsfit_pkg::DEN_W-1:0] : rem_sh[lsfit_pkg::DEN_W-1:0];
            q_next   = {q_reg[lsfit_pkg::Q_W-2:0], ge};
            ovf_next = ovf_reg | q_reg[lsfit_pkg::Q_W-1];
            dvd_next = dvd_reg << 1;
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // rounding and saturation of the finished quotient
    assign rnd   = ({rem_reg, 1'b0} >= {1'b0, den_reg});
    assign q_rnd = {1'b0, q_reg} + {{lsfit_pkg::Q_W{1'b0}}, rnd};
    assign sat   = ovf_reg || (neg_reg ? (q_rnd > lsfit_pkg::NEG_LIM)
                                       : (q_rnd > lsfit_pkg::POS_LIM));

    always_comb
    begin
        if (sat)
        begin
            quot = neg_reg ? lsfit_pkg::FX_MIN : lsfit_pkg::FX_MAX;
        end
        else if (neg_reg)
        begin
            quot = -$signed(q_rnd[lsfit_pkg::FX_W-1:0]);
        end
        else
        begin
            quot = $signed(q_rnd[lsfit_pkg::FX_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

    assign run = run_reg;

endmodule

`default_nettype wire

// ===== design/least_squares_line_fit.sv =====
// Top level of the least-squares line fit: sequencer, accumulators and result registers.
`default_nettype none

// Least-squares line fit for a sheet counter. A beat is taken when start is
// high and busy is low. Calibration beats (req_type = 0) add freq_count and
// sheet_count into the running sums; the beat with last_point set also fits
// p = slope*f + intercept (signed, FRAC_BITS fraction bits) and clears the
// sums. Only the first MAX_POINTS points are summed; a last mark beyond that
// still fits. A zero denominator keeps the old line and sets degenerate.
// Estimate beats (req_type = 1) give slope*f + intercept rounded half up and
// clamped to 0..65535. Every fit and every estimate yields one result beat,
// shown for exactly one cycle with done high; non-last calibration beats give
// none. There is no back-pressure: the receiver must take done when it comes.
// Timing: all products go through one bit-serial multiply-accumulate unit, one
// multiplier bit a cycle, and both fit quotients through one radix-2 divider
// of 70 steps. An estimate is one serial product; a summed calibration point
// is two (f*f, f*p); the fit adds six serial products and two divisions.
// done rises at the edge where busy falls.
module least_squares_line_fit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                req_type,
    input  wire logic [lsfit_pkg::F_W-1:0]           freq_count,
    input  wire logic [lsfit_pkg::P_W-1:0]           sheet_count,
    input  wire logic                                last_point,
    output logic                                     done,
    output logic                                     result_kind,
    output logic signed [lsfit_pkg::FX_W-1:0]        slope_out,
    output logic signed [lsfit_pkg::FX_W-1:0]        intercept_out,
    output logic [lsfit_pkg::EST_W-1:0]              sheet_estimate,
    output logic                                     degenerate
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_SQ,   // sum_freq_sq  += f*f
        ST_ACC_FP,   // sum_freq_sheet += f*p
        ST_FIT,      // sums settled, launch the fit
        ST_DEN_A,    // n*Sff
        ST_DEN_B,    //   - Sf*Sf
        ST_SN_A,     // n*Sfp
        ST_SN_B,     //   - Sf*Sp
        ST_IN_A,     // Sff*Sp
        ST_IN_B,     //   - Sfp*Sf
        ST_DIV_S,    // slope quotient
        ST_DIV_I,    // intercept quotient
        ST_EST       // slope*f + intercept
    } state_t;

    state_t state_reg, state_next;

    // latched beat
    logic [lsfit_pkg::F_W-1:0]   f_reg, f_next;
    logic [lsfit_pkg::P_W-1:0]   p_reg, p_next;
    logic                        last_reg, last_next;

    // running sums
    logic [lsfit_pkg::SFF_W-1:0] sff_reg, sff_next;
    logic [lsfit_pkg::SF_W-1:0]  sf_reg, sf_next;
    logic [lsfit_pkg::SFP_W-1:0] sfp_reg, sfp_next;
    logic [lsfit_pkg::SP_W-1:0]  sp_reg, sp_next;
    logic [lsfit_pkg::CNT_W-1:0] pt_reg, pt_next;

    // line in use
    logic signed [lsfit_pkg::FX_W-1:0] slope_reg, slope_next;
    logic signed [lsfit_pkg::FX_W-1:0] intercept_reg, intercept_next;

    // fit intermediates
    logic [lsfit_pkg::DEN_W-1:0]        den_reg, den_next;
    logic signed [lsfit_pkg::NUM_W-1:0] snum_reg, snum_next;
    logic signed [lsfit_pkg::NUM_W-1:0] inum_reg, inum_next;

    // result registers
    logic                              done_reg, done_next;
    logic                              kind_reg, kind_next;
    logic signed [lsfit_pkg::FX_W-1:0] slope_o_reg, slope_o_next;
    logic signed [lsfit_pkg::FX_W-1:0] icpt_o_reg, icpt_o_next;
    logic [lsfit_pkg::EST_W-1:0]       est_reg, est_next;
    logic                              degen_reg, degen_next;

    // arithmetic units
    lsfit_pkg::mac_cmd_t                mac_cmd;
    logic                               mac_run;
    logic signed [lsfit_pkg::ACC_W-1:0] mac_acc;
    lsfit_pkg::div_cmd_t                div_cmd;
    logic                               div_run;
    logic signed [lsfit_pkg::FX_W-1:0]  div_quot;

    // estimate rounding
    logic [lsfit_pkg::ACC_W-1:0]                    est_sum;
    logic [lsfit_pkg::ACC_W-lsfit_pkg::FRAC_BITS-1:0] est_hi;
    logic [lsfit_pkg::EST_W-1:0]                    est_val;
    logic                                           den_zero;

    lsfit_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .run   (mac_run),
        .acc   (mac_acc)
    );

    lsfit_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .run   (div_run),
        .quot  (div_quot)
    );

    // add the half, floor, clamp to the output range
    assign est_sum = $unsigned(mac_acc) + lsfit_pkg::EST_HALF;
    assign est_hi  = est_sum[lsfit_pkg::ACC_W-1:lsfit_pkg::FRAC_BITS];

    always_comb
    begin
        if (mac_acc[lsfit_pkg::ACC_W-1])
        begin
            est_val = '0;
        end
        else if (|est_hi[lsfit_pkg::ACC_W-lsfit_pkg::FRAC_BITS-1:lsfit_pkg::EST_W])
        begin
            est_val = lsfit_pkg::EST_MAX;
        end
        else
        begin
            est_val = est_hi[lsfit_pkg::EST_W-1:0];
        end
    end

    // D <= 0 counts as degenerate
    assign den_zero = mac_acc[lsfit_pkg::ACC_W-1] || (mac_acc == '0);

    always_comb
    begin
        state_next     = state_reg;
        f_next         = f_reg;
        p_next         = p_reg;
        last_next      = last_reg;
        sff_next       = sff_reg;
        sf_next        = sf_reg;
        sfp_next       = sfp_reg;
        sp_next        = sp_reg;
        pt_next        = pt_reg;
        slope_next     = slope_reg;
        intercept_next = intercept_reg;
        den_next       = den_reg;
        snum_next      = snum_reg;
        inum_next      = inum_reg;
        done_next      = 1'b0;
        kind_next      = kind_reg;
        slope_o_next   = slope_o_reg;
        icpt_o_next    = icpt_o_reg;
        est_next       = est_reg;
        degen_next     = degen_reg;
        mac_cmd        = '0;
        div_cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    f_next    = freq_count;
                    p_next    = sheet_count;
                    last_next = last_point;
                    if (req_type == lsfit_pkg::REQ_EST)
                    begin
                        mac_cmd.load = 1'b1;
                        mac_cmd.init = {{(lsfit_pkg::ACC_W-lsfit_pkg::FX_W)
                                         {intercept_reg[lsfit_pkg::FX_W-1]}}, intercept_reg};
                        mac_cmd.a    = slope_reg;
                        mac_cmd.b    = {{(lsfit_pkg::B_W-lsfit_pkg::F_W){1'b0}}, freq_count};
                        state_next   = ST_EST;
                    end
                    else if (pt_reg < lsfit_pkg::MAX_PT)
                    begin
                        mac_cmd.load = 1'b1;
                        mac_cmd.init = {{(lsfit_pkg::ACC_W-lsfit_pkg::SFF_W){1'b0}}, sff_reg};
                        mac_cmd.a    = {{(lsfit_pkg::A_W-lsfit_pkg::F_W){1'b0}}, freq_count};
                        mac_cmd.b    = {{(lsfit_pkg::B_W-lsfit_pkg::F_W){1'b0}}, freq_count};
                        state_next   = ST_ACC_SQ;
                    end
                    else if (last_point)
                    begin
                        // table full: fit over what is held
                        state_next = ST_FIT;
                    end
                end
            end

            ST_ACC_SQ:
            begin
                if (!mac_run)
                begin
                    sff_next     = mac_acc[lsfit_pkg::SFF_W-1:0];
                    mac_cmd.load = 1'b1;
                    mac_cmd.init = {{(lsfit_pkg::ACC_W-lsfit_pkg::SFP_W){1'b0}}, sfp_reg};
                    mac_cmd.a    = {{(lsfit_pkg::A_W-lsfit_pkg::F_W){1'b0}}, f_reg};
                    mac_cmd.b    = {{(lsfit_pkg::B_W-lsfit_pkg::P_W){1'b0}}, p_reg};
                    state_next   = ST_ACC_FP;
                end
            end

            ST_ACC_FP:
            begin
                if (!mac_run)
                begin
                    sfp_next   = mac_acc[lsfit_pkg::SFP_W-1:0];
                    sf_next    = sf_reg + {{(lsfit_pkg::SF_W-lsfit_pkg::F_W){1'b0}}, f_reg};
                    sp_next    = sp_reg + {{(lsfit_pkg::SP_W-lsfit_pkg::P_W){1'b0}}, p_reg};
                    pt_next    = pt_reg + lsfit_pkg::PT_ONE;
                    state_next = last_reg ? ST_FIT : ST_IDLE;
                end
            end

            ST_FIT:
            begin
                mac_cmd.load = 1'b1;
                mac_cmd.init = '0;
                mac_cmd.a    = {{(lsfit_pkg::A_W-lsfit_pkg::SFF_W){1'b0}}, sff_reg};
                mac_cmd.b    = {{(lsfit_pkg::B_W-lsfit_pkg::CNT_W){1'b0}}, pt_reg};
                state_next   = ST_DEN_A;
            end

            ST_DEN_A:
            begin
                if (!mac_run)
                begin
                    mac_cmd.load = 1'b1;
                    mac_cmd.sub  = 1'b1;
                    mac_cmd.init = mac_acc;
                    mac_cmd.a    = {{(lsfit_pkg::A_W-lsfit_pkg::SF_W){1'b0}}, sf_reg};
                    mac_cmd.b    = sf_reg;
                    state_next   = ST_DEN_B;
                end
            end

            ST_DEN_B:
            begin
                if (!mac_run)
                begin
                    den_next = mac_acc[lsfit_pkg::DEN_W-1:0];
                    if (den_zero)
                    begin
                        // keep the old line, flag it, drop the sums
                        done_next    = 1'b1;
                        kind_next    = lsfit_pkg::RK_FIT;
                        slope_o_next = slope_reg;
                        icpt_o_next  = intercept_reg;
                        est_next     = '0;
                        degen_next   = 1'b1;
                        sff_next     = '0;
                        sf_next      = '0;
                        sfp_next     = '0;
                        sp_next      = '0;
                        pt_next      = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        mac_cmd.load = 1'b1;
                        mac_cmd.init = '0;
                        mac_cmd.a    = {{(lsfit_pkg::A_W-lsfit_pkg::SFP_W){1'b0}}, sfp_reg};
                        mac_cmd.b    = {{(lsfit_pkg::B_W-lsfit_pkg::CNT_W){1'b0}}, pt_reg};
                        state_next   = ST_SN_A;
                    end
                end
            end

            ST_SN_A:
            begin
                if (!mac_run)
                begin
                    mac_cmd.load = 1'b1;
                    mac_cmd.sub  = 1'b1;
                    mac_cmd.init = mac_acc;
                    mac_cmd.a    = {{(lsfit_pkg::A_W-lsfit_pkg::SF_W){1'b0}}, sf_reg};
                    mac_cmd.b    = {{(lsfit_pkg::B_W-lsfit_pkg::SP_W){1'b0}}, sp_reg};
                    state_next   = ST_SN_B;
                end
            end

            ST_SN_B:
            begin
                if (!mac_run)
                begin
                    snum_next    = mac_acc[lsfit_pkg::NUM_W-1:0];
                    mac_cmd.load = 1'b1;
                    mac_cmd.init = '0;
                    mac_cmd.a    = {{(lsfit_pkg::A_W-lsfit_pkg::SFF_W){1'b0}}, sff_reg};
                    mac_cmd.b    = {{(lsfit_pkg::B_W-lsfit_pkg::SP_W){1'b0}}, sp_reg};
                    state_next   = ST_IN_A;
                end
            end

            ST_IN_A:
            begin
                if (!mac_run)
                begin
                    mac_cmd.load = 1'b1;
                    mac_cmd.sub  = 1'b1;
                    mac_cmd.init = mac_acc;
                    mac_cmd.a    = {{(lsfit_pkg::A_W-lsfit_pkg::SFP_W){1'b0}}, sfp_reg};
                    mac_cmd.b    = sf_reg;
                    state_next   = ST_IN_B;
                end
            end

            ST_IN_B:
            begin
                if (!mac_run)
                begin
                    inum_next    = mac_acc[lsfit_pkg::NUM_W-1:0];
                    div_cmd.load = 1'b1;
                    div_cmd.num  = snum_reg;
                    div_cmd.den  = den_reg;
                    state_next   = ST_DIV_S;
                end
            end

            ST_DIV_S:
            begin
                if (!div_run)
                begin
                    slope_next   = div_quot;
                    div_cmd.load = 1'b1;
                    div_cmd.num  = inum_reg;
                    div_cmd.den  = den_reg;
                    state_next   = ST_DIV_I;
                end
            end

            ST_DIV_I:
            begin
                if (!div_run)
                begin
                    intercept_next = div_quot;
                    done_next      = 1'b1;
                    kind_next      = lsfit_pkg::RK_FIT;
                    slope_o_next   = slope_reg;
                    icpt_o_next    = div_quot;
                    est_next       = '0;
                    degen_next     = 1'b0;
                    sff_next       = '0;
                    sf_next        = '0;
                    sfp_next       = '0;
                    sp_next        = '0;
                    pt_next        = '0;
                    state_next     = ST_IDLE;
                end
            end

            ST_EST:
            begin
                if (!mac_run)
                begin
                    done_next    = 1'b1;
                    kind_next    = lsfit_pkg::RK_EST;
                    slope_o_next = slope_reg;
                    icpt_o_next  = intercept_reg;
                    est_next     = est_val;
                    degen_next   = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sff_reg       <= '0;
            sf_reg        <= '0;
            sfp_reg       <= '0;
            sp_reg        <= '0;
            pt_reg        <= '0;
            slope_reg     <= '0;
            intercept_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sff_reg       <= sff_next;
            sf_reg        <= sf_next;
            sfp_reg       <= sfp_next;
            sp_reg        <= sp_next;
            pt_reg        <= pt_next;
            slope_reg     <= slope_next;
            intercept_reg <= intercept_next;
            done_reg      <= done_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        f_reg       <= f_next;
        p_reg       <= p_next;
        last_reg    <= last_next;
        den_reg     <= den_next;
        snum_reg    <= snum_next;
        inum_reg    <= inum_next;
        kind_reg    <= kind_next;
        slope_o_reg <= slope_o_next;
        icpt_o_reg  <= icpt_o_next;
        est_reg     <= est_next;
        degen_reg   <= degen_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign result_kind    = kind_reg;
    assign slope_out      = slope_o_reg;
    assign intercept_out  = icpt_o_reg;
    assign sheet_estimate = est_reg;
    assign degenerate     = degen_reg;

    // a result beat always closes a busy stretch
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without preceding work");

    // neither arithmetic unit may still be running once the sequencer is idle
    a_units_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(mac_run || div_run))
        else $error("arithmetic unit running while idle");

    // the point count never passes the table size
    a_point_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pt_reg <= lsfit_pkg::MAX_PT)
        else $error("point count beyond limit");

    // an estimate beat never carries the degenerate flag
    a_est_not_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result_kind == lsfit_pkg::RK_EST)) |-> !degenerate)
        else $error("degenerate flag on estimate");

endmodule

`default_nettype wire
